// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bfms_pkg.sv =====
// ----------------------------------------------------------------------------
// bfms_pkg
// shared types and constants of the best format match selector
// ----------------------------------------------------------------------------
package bfms_pkg;

    localparam int MAX_CANDIDATES_DEF   = 256;
    localparam int CHANNEL_BITS_MAX_DEF = 32;

    // per-channel bit count width and running cost width
    // (four squared distances of at most 63 plus mapping and type terms fit 16 bits)
    localparam int BITS_W = 6;
    localparam int COST_W = 16;
    localparam int OUT_COST_W = 14;

    localparam int MISSING_WEIGHT = 1000;
    localparam int TYPE_PENALTY   = 100;
    localparam int COST_OUT_MAX   = 16383;

    localparam int FLAG_LUMA = 4;
    localparam logic [4:0] RGB_FLAGS = 5'b00111;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_API_VERSION   = 3'd0,
        CFG_SWIZZLE       = 3'd1,
        CFG_CHANNEL_COUNT = 3'd2,
        CFG_CHANNEL_FLAGS = 3'd3,
        CFG_CHANNEL_BITS  = 3'd4,
        CFG_IMAGE_TYPE    = 3'd5
    } cfg_reg_t;

    function automatic logic [2:0] ones5(input logic [4:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < 5; i++)
        begin
            n = n + 3'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== src/best_format_match_selector.sv =====
// ----------------------------------------------------------------------------
// best_format_match_selector
// picks the cheapest version-eligible candidate format from a streamed list
// ----------------------------------------------------------------------------
// Takes one candidate beat per clock with no gaps needed while in_stall is low.
// Each accepted beat lands in an item register; the full cost (mapping, squared
// bit distance, type penalty), the version check and the compare against the
// running minimum are done in the single logic stage that follows, so the result
// for a list is loaded into the output register as its last beat leaves the
// item register. Input stall rises only when a finished result still waits on
// a stalled output and the next last beat is ready to replace it. Ties keep the
// earlier candidate; candidates past MAX_CANDIDATES are counted out. The
// configuration port is always ready and must be written between lists.
module best_format_match_selector #(
    parameter int MAX_CANDIDATES   = bfms_pkg::MAX_CANDIDATES_DEF,
    parameter int CHANNEL_BITS_MAX = bfms_pkg::CHANNEL_BITS_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bfms_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bfms_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [15:0]                         min_version,
    input  logic [15:0]                         max_version,
    input  logic [2:0]                          cand_channel_count,
    input  logic [4:0]                          cand_channel_flags,
    input  logic [5:0]                          cand_bits_x,
    input  logic [5:0]                          cand_bits_y,
    input  logic [5:0]                          cand_bits_z,
    input  logic [5:0]                          cand_bits_w,
    input  logic [3:0]                          cand_type,
    input  logic                                last_candidate,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          best_index,
    output logic [bfms_pkg::OUT_COST_W-1:0]     best_cost,
    output logic                                found
);

    localparam int POS_W  = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W  = $clog2(MAX_CANDIDATES);
    localparam int BITS_W = bfms_pkg::BITS_W;
    localparam int COST_W = bfms_pkg::COST_W;
    localparam int OUT_W  = bfms_pkg::OUT_COST_W;
    localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(MAX_CANDIDATES);
    localparam logic [BITS_W-1:0] BITS_CAP  = BITS_W'(CHANNEL_BITS_MAX);

    // configuration registers
    logic [15:0] api_version_reg;
    logic        swizzle_reg;
    logic [2:0]  img_count_reg;
    logic [4:0]  img_flags_reg;
    logic [23:0] img_bits_reg;
    logic [3:0]  img_type_reg;

    // item register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [15:0]       min_ver_reg;
    logic [15:0]       max_ver_reg;
    logic [2:0]        cc_reg;
    logic [4:0]        cf_reg;
    logic [BITS_W-1:0] cb_reg [4];
    logic [3:0]        ctype_reg;
    logic              last_reg;

    // running selection state
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [IDX_W-1:0]  chosen_reg;
    logic [IDX_W-1:0]  chosen_next;
    logic [COST_W-1:0] lowest_reg;
    logic [COST_W-1:0] lowest_next;
    logic              any_reg;
    logic              any_next;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        best_index_reg;
    logic [OUT_W-1:0]  best_cost_reg;
    logic              found_reg;

    logic              in_accept;
    logic              s1_go;
    logic              s1_fire;
    logic              out_load;
    logic [COST_W-1:0] cost;
    logic              eligible;
    logic              better;
    logic              upd_any;
    logic [COST_W-1:0] upd_cost;
    logic [IDX_W-1:0]  upd_chosen;
    logic [IDX_W+7:0]  idx_wide;
    logic [OUT_W-1:0]  cost_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            api_version_reg <= '0;
            swizzle_reg     <= 1'b0;
            img_count_reg   <= '0;
            img_flags_reg   <= '0;
            img_bits_reg    <= '0;
            img_type_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (bfms_pkg::cfg_reg_t'(cfg_index))
                bfms_pkg::CFG_API_VERSION:   api_version_reg <= cfg_data[15:0];
                bfms_pkg::CFG_SWIZZLE:       swizzle_reg     <= cfg_data[0];
                bfms_pkg::CFG_CHANNEL_COUNT: img_count_reg   <= cfg_data[2:0];
                bfms_pkg::CFG_CHANNEL_FLAGS: img_flags_reg   <= cfg_data[4:0];
                bfms_pkg::CFG_CHANNEL_BITS:  img_bits_reg    <= cfg_data[23:0];
                bfms_pkg::CFG_IMAGE_TYPE:    img_type_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // handshake: a held item moves on unless it would overwrite a waiting result
    assign s1_go     = !last_reg || !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && s1_go;
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;
    assign out_load  = s1_fire && last_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            min_ver_reg <= min_version;
            max_ver_reg <= max_version;
            cc_reg      <= cand_channel_count;
            cf_reg      <= cand_channel_flags;
            cb_reg[0]   <= cand_bits_x;
            cb_reg[1]   <= cand_bits_y;
            cb_reg[2]   <= cand_bits_z;
            cb_reg[3]   <= cand_bits_w;
            ctype_reg   <= cand_type;
            last_reg    <= last_candidate;
        end
    end

    // candidate cost
    always_comb
    begin
        logic [BITS_W-1:0] cb [4];
        logic [BITS_W-1:0] ib [4];
        logic [BITS_W-1:0] raw;
        logic [BITS_W-1:0] d;
        logic [4:0]        imf;
        logic [13:0]       layout;
        logic [12:0]       mapping;
        logic              luma_split;

        layout = '0;
        for (int i = 0; i < 4; i++)
        begin
            cb[i] = (cb_reg[i] > BITS_CAP) ? BITS_CAP : cb_reg[i];
            raw   = img_bits_reg[BITS_W*i +: BITS_W];
            ib[i] = (raw > BITS_CAP) ? BITS_CAP : raw;
        end

        imf        = img_flags_reg;
        luma_split = !swizzle_reg && img_flags_reg[bfms_pkg::FLAG_LUMA]
                     && !cf_reg[bfms_pkg::FLAG_LUMA];
        if (luma_split)
        begin
            imf                         = img_flags_reg | bfms_pkg::RGB_FLAGS;
            imf[bfms_pkg::FLAG_LUMA]    = 1'b0;
            ib[3]                       = ib[1];
            ib[1]                       = ib[0];
            ib[2]                       = ib[0];
        end

        if (swizzle_reg)
        begin
            if (cc_reg >= img_count_reg)
            begin
                mapping = 13'(cc_reg - img_count_reg);
            end
            else
            begin
                mapping = 13'(img_count_reg - cc_reg) * 13'(bfms_pkg::MISSING_WEIGHT);
            end
        end
        else
        begin
            mapping = 13'(bfms_pkg::ones5(cf_reg & ~imf))
                    + 13'(bfms_pkg::ones5(imf & ~cf_reg)) * 13'(bfms_pkg::MISSING_WEIGHT);
        end

        for (int i = 0; i < 4; i++)
        begin
            d      = (ib[i] >= cb[i]) ? (ib[i] - cb[i]) : (cb[i] - ib[i]);
            layout = layout + 14'(12'(d) * 12'(d));
        end

        cost = COST_W'(mapping) + COST_W'(layout)
             + ((ctype_reg != img_type_reg) ? COST_W'(bfms_pkg::TYPE_PENALTY) : '0);
    end

    assign eligible = (pos_reg < POS_LIMIT)
                   && (api_version_reg >= min_ver_reg)
                   && (api_version_reg <= max_ver_reg);
    assign better     = eligible && (!any_reg || (cost < lowest_reg));
    assign upd_any    = any_reg || better;
    assign upd_cost   = better ? cost : lowest_reg;
    assign upd_chosen = better ? pos_reg[IDX_W-1:0] : chosen_reg;
    assign idx_wide   = {8'd0, upd_chosen};
    assign cost_sat   = (upd_cost > COST_W'(bfms_pkg::COST_OUT_MAX))
                      ? OUT_W'(bfms_pkg::COST_OUT_MAX) : upd_cost[OUT_W-1:0];

    always_comb
    begin
        pos_next    = pos_reg;
        chosen_next = chosen_reg;
        lowest_next = lowest_reg;
        any_next    = any_reg;
        if (s1_fire)
        begin
            if (last_reg)
            begin
                // list done, start the next one clean
                pos_next    = '0;
                chosen_next = '0;
                lowest_next = '0;
                any_next    = 1'b0;
            end
            else
            begin
                pos_next    = (pos_reg < POS_LIMIT) ? pos_reg + POS_W'(1) : pos_reg;
                chosen_next = upd_chosen;
                lowest_next = upd_cost;
                any_next    = upd_any;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            chosen_reg    <= '0;
            lowest_reg    <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pos_reg       <= pos_next;
            chosen_reg    <= chosen_next;
            lowest_reg    <= lowest_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            best_index_reg <= upd_any ? idx_wide[7:0] : 8'd0;
            best_cost_reg  <= upd_any ? cost_sat : '0;
            found_reg      <= upd_any;
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_index = best_index_reg;
    assign best_cost  = best_cost_reg;
    assign found      = found_reg;

endmodule

// ===== src/bfms_checker.sv =====
// ----------------------------------------------------------------------------
// bfms_checker
// port-level checks of the best format match selector
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfms_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [7:0]                      best_index,
    input  logic [bfms_pkg::OUT_COST_W-1:0] best_cost,
    input  logic                            found
);

    // a result beat held back by the sink keeps its value
    `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(best_index) && $stable(best_cost) && $stable(found), "stalled result beat changed")

    // with nothing eligible the index and cost read as zero
    `ASSERT_CLKD(a_empty_zero, clk, rst_n, out_valid && !found |-> best_index == 8'd0 && best_cost == '0, "empty result carries data")

    // input backpressure only comes from a stalled waiting result
    `ASSERT_CLKD(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled without output backpressure")

    // nothing leaves right after reset
    `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result beat straight after reset")

endmodule

bind best_format_match_selector bfms_checker u_bfms_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_index (best_index),
    .best_cost  (best_cost),
    .found      (found)
);
